@@ src/dmtlb_pkg.sv @@
// Shared types and constants for the direct-mapped TLB with two-level page walk.
// Holds address split widths, controller states, outcomes and the command/status structs.
// No dependencies.
package dmtlb_pkg;

    // Address split
    localparam int DIR_BITS  = 10;
    localparam int TAB_BITS  = 10;
    localparam int OFF_BITS  = 12;
    localparam int VA_W      = 32;
    localparam int FRAME_W   = VA_W - OFF_BITS;
    localparam int LEAF_BITS = DIR_BITS + TAB_BITS;

    // Frame counter and statistics widths
    localparam int NF_W  = 21;
    localparam int CNT_W = 32;
    localparam logic [NF_W-1:0] LIMIT_RESET = NF_W'(1000000);

    // Leaf valid bits are stored in rows to keep the clearing pass short
    localparam int LV_SEL_BITS = (LEAF_BITS > 6) ? 5 : 1;
    localparam int LV_ROW_BITS = LEAF_BITS - LV_SEL_BITS;
    localparam int LV_WIDTH    = 1 << LV_SEL_BITS;

    // Clearing pass covers the deepest of the cleared stores
    localparam int CLR_BITS_A = (LV_ROW_BITS > DIR_BITS) ? LV_ROW_BITS : DIR_BITS;
    localparam int CLR_BITS   = (CLR_BITS_A > TAB_BITS) ? CLR_BITS_A : TAB_BITS;

    typedef enum logic [1:0] {
        OUT_HIT       = 2'd0,
        OUT_COLD      = 2'd1,
        OUT_CONFLICT  = 2'd2,
        OUT_EXHAUSTED = 2'd3
    } outcome_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_ROOT,
        ST_DIR,
        ST_LEAF,
        ST_FILL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             valid;
        logic [DIR_BITS-1:0] tag;
        logic [FRAME_W-1:0]  frame;
    } line_t;

    // Controller -> datapath
    typedef struct packed {
        logic rd_en;
        logic clr_en;
        logic look;
        logic alloc;
        logic set_root;
        logic set_dir;
        logic set_leaf;
        logic fill;
        logic load_out;
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic halted;
        logic hit;
        logic root_present;
        logic dir_valid;
        logic leaf_valid;
        logic alloc_last;
        logic out_free;
    } dp_sts_t;

endpackage

@@ src/dmtlb_ctrl.sv @@
// Controller state machine for the TLB: clearing pass, lookup, page walk, refill, response.
// Depends on dmtlb_pkg.
module dmtlb_ctrl
    import dmtlb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                cmd.look = 1'b1;
                if (sts.halted || sts.hit)
                begin
                    state_next = ST_DONE;
                end
                else if (!sts.root_present)
                begin
                    state_next = ST_ROOT;
                end
                else if (!sts.dir_valid)
                begin
                    state_next = ST_DIR;
                end
                else if (!sts.leaf_valid)
                begin
                    state_next = ST_LEAF;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end
            ST_ROOT:
            begin
                cmd.alloc    = 1'b1;
                cmd.set_root = 1'b1;
                if (sts.alloc_last)
                begin
                    state_next = ST_DONE;
                end
                else if (!sts.dir_valid)
                begin
                    state_next = ST_DIR;
                end
                else if (!sts.leaf_valid)
                begin
                    state_next = ST_LEAF;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end
            ST_DIR:
            begin
                cmd.alloc   = 1'b1;
                cmd.set_dir = 1'b1;
                if (sts.alloc_last)
                begin
                    state_next = ST_DONE;
                end
                else if (!sts.leaf_valid)
                begin
                    state_next = ST_LEAF;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end
            ST_LEAF:
            begin
                cmd.alloc    = 1'b1;
                cmd.set_leaf = 1'b1;
                if (sts.alloc_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                cmd.fill   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

@@ src/dmtlb_dp.sv @@
// Datapath for the TLB: line, directory and leaf stores, frame counter, statistics, result register.
// Depends on dmtlb_pkg; driven by dmtlb_ctrl.
module dmtlb_dp
    import dmtlb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [VA_W-1:0]   in_va,
    input  logic              cfg_we,
    input  logic [NF_W-1:0]   cfg_wdata,
    input  dp_cmd_t           cmd,
    output dp_sts_t           sts,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [VA_W-1:0]   out_pa,
    output outcome_t          out_outcome,
    output logic [CNT_W-1:0]  out_hits,
    output logic [CNT_W-1:0]  out_cold,
    output logic [CNT_W-1:0]  out_conflict
);

    localparam int TAB_DEPTH  = 1 << TAB_BITS;
    localparam int DIR_DEPTH  = 1 << DIR_BITS;
    localparam int LEAF_DEPTH = 1 << LEAF_BITS;
    localparam int LV_ROWS    = 1 << LV_ROW_BITS;

    // Stores
    line_t               line_mem [TAB_DEPTH];
    logic                dir_mem  [DIR_DEPTH];
    logic [LV_WIDTH-1:0] lv_mem   [LV_ROWS];
    logic [FRAME_W-1:0]  lf_mem   [LEAF_DEPTH];

    // Read data registers
    line_t               line_rd_reg;
    logic                dir_rd_reg;
    logic [LV_WIDTH-1:0] lv_rd_reg;
    logic [FRAME_W-1:0]  lf_rd_reg;

    // Control and payload registers
    logic [CLR_BITS-1:0] clr_idx_reg;
    logic                halted_reg;
    logic                root_reg;
    logic [NF_W-1:0]     next_frame_reg;
    logic [NF_W-1:0]     limit_reg;
    logic [CNT_W-1:0]    hits_reg;
    logic [CNT_W-1:0]    cold_reg;
    logic [CNT_W-1:0]    conflict_reg;
    logic [VA_W-1:0]     va_reg;
    logic [FRAME_W-1:0]  frame_reg;
    outcome_t            outcome_reg;
    logic                out_valid_reg;
    logic [VA_W-1:0]     out_pa_reg;
    outcome_t            out_outcome_reg;
    logic [CNT_W-1:0]    out_hits_reg;
    logic [CNT_W-1:0]    out_cold_reg;
    logic [CNT_W-1:0]    out_conflict_reg;

    // Address fields of the incoming and the held request
    logic [TAB_BITS-1:0]    in_tab;
    logic [DIR_BITS-1:0]    in_dir;
    logic [LEAF_BITS-1:0]   in_leaf;
    logic [OFF_BITS-1:0]    va_off;
    logic [TAB_BITS-1:0]    va_tab;
    logic [DIR_BITS-1:0]    va_dir;
    logic [LEAF_BITS-1:0]   va_leaf;
    logic [LV_ROW_BITS-1:0] va_lv_row;
    logic [LV_SEL_BITS-1:0] va_lv_sel;
    logic                   line_hit;
    logic                   leaf_bit;
    logic [NF_W-1:0]        nf_inc;
    logic                   alloc_last;
    logic                   out_free;

    assign in_tab    = in_va[OFF_BITS +: TAB_BITS];
    assign in_dir    = in_va[OFF_BITS + TAB_BITS +: DIR_BITS];
    assign in_leaf   = {in_dir, in_tab};
    assign va_off    = va_reg[OFF_BITS-1:0];
    assign va_tab    = va_reg[OFF_BITS +: TAB_BITS];
    assign va_dir    = va_reg[OFF_BITS + TAB_BITS +: DIR_BITS];
    assign va_leaf   = {va_dir, va_tab};
    assign va_lv_row = va_leaf[LEAF_BITS-1:LV_SEL_BITS];
    assign va_lv_sel = va_leaf[LV_SEL_BITS-1:0];

    assign line_hit   = line_rd_reg.valid && (line_rd_reg.tag == va_dir);
    assign leaf_bit   = lv_rd_reg[va_lv_sel];
    assign nf_inc     = next_frame_reg + 1'b1;
    assign alloc_last = (nf_inc == limit_reg);
    assign out_free   = !out_valid_reg || out_ready;

    assign sts.clr_done     = &clr_idx_reg;
    assign sts.halted       = halted_reg;
    assign sts.hit          = line_hit;
    assign sts.root_present = root_reg;
    assign sts.dir_valid    = dir_rd_reg;
    assign sts.leaf_valid   = leaf_bit;
    assign sts.alloc_last   = alloc_last;
    assign sts.out_free     = out_free;

    // TLB line store
    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
        begin
            line_mem[clr_idx_reg[TAB_BITS-1:0]] <= '0;
        end
        else if (cmd.fill)
        begin
            line_mem[va_tab] <= '{valid: 1'b1, tag: va_dir, frame: frame_reg};
        end
        if (cmd.rd_en)
        begin
            line_rd_reg <= line_mem[in_tab];
        end
    end

    // Directory valid store
    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
        begin
            dir_mem[clr_idx_reg[DIR_BITS-1:0]] <= 1'b0;
        end
        else if (cmd.set_dir && !alloc_last)
        begin
            dir_mem[va_dir] <= 1'b1;
        end
        if (cmd.rd_en)
        begin
            dir_rd_reg <= dir_mem[in_dir];
        end
    end

    // Leaf valid rows
    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
        begin
            lv_mem[clr_idx_reg[LV_ROW_BITS-1:0]] <= '0;
        end
        else if (cmd.set_leaf && !alloc_last)
        begin
            lv_mem[va_lv_row] <= lv_rd_reg | (LV_WIDTH'(1) << va_lv_sel);
        end
        if (cmd.rd_en)
        begin
            lv_rd_reg <= lv_mem[in_leaf[LEAF_BITS-1:LV_SEL_BITS]];
        end
    end

    // Leaf frame store, undefined until written
    always_ff @(posedge clk)
    begin
        if (cmd.set_leaf && !alloc_last)
        begin
            lf_mem[va_leaf] <= next_frame_reg[FRAME_W-1:0];
        end
        if (cmd.rd_en)
        begin
            lf_rd_reg <= lf_mem[in_leaf];
        end
    end

    // Clearing pass index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (cmd.clr_en)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    // Frame limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // Walk state: frame counter, root, halt, statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halted_reg     <= 1'b0;
            root_reg       <= 1'b0;
            next_frame_reg <= '0;
            hits_reg       <= '0;
            cold_reg       <= '0;
            conflict_reg   <= '0;
        end
        else
        begin
            if (cmd.look && !halted_reg && line_hit)
            begin
                hits_reg <= hits_reg + 1'b1;
            end
            if (cmd.alloc)
            begin
                next_frame_reg <= nf_inc;
                if (alloc_last)
                begin
                    halted_reg <= 1'b1;
                end
            end
            if (cmd.set_root && !alloc_last)
            begin
                root_reg <= 1'b1;
            end
            if (cmd.fill)
            begin
                if (outcome_reg == OUT_COLD)
                begin
                    cold_reg <= cold_reg + 1'b1;
                end
                else
                begin
                    conflict_reg <= conflict_reg + 1'b1;
                end
            end
        end
    end

    // Request payload, frame and outcome of the current request
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            va_reg <= in_va;
        end
        if (cmd.look)
        begin
            if (halted_reg)
            begin
                outcome_reg <= OUT_EXHAUSTED;
            end
            else if (line_hit)
            begin
                outcome_reg <= OUT_HIT;
            end
            else if (line_rd_reg.valid)
            begin
                outcome_reg <= OUT_CONFLICT;
            end
            else
            begin
                outcome_reg <= OUT_COLD;
            end
            frame_reg <= line_hit ? line_rd_reg.frame : lf_rd_reg;
        end
        if (cmd.alloc && alloc_last)
        begin
            outcome_reg <= OUT_EXHAUSTED;
        end
        else if (cmd.set_leaf)
        begin
            frame_reg <= next_frame_reg[FRAME_W-1:0];
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_pa_reg       <= (outcome_reg == OUT_EXHAUSTED) ? '0 : {frame_reg, va_off};
            out_outcome_reg  <= outcome_reg;
            out_hits_reg     <= hits_reg;
            out_cold_reg     <= cold_reg;
            out_conflict_reg <= conflict_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_pa       = out_pa_reg;
    assign out_outcome  = out_outcome_reg;
    assign out_hits     = out_hits_reg;
    assign out_cold     = out_cold_reg;
    assign out_conflict = out_conflict_reg;

    // No frame is taken once the supply is exhausted
    a_no_alloc_halted: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |-> !halted_reg)
        else $error("frame allocated while halted");

    // Exhausting allocation halts the block
    a_last_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.alloc && alloc_last) |=> halted_reg)
        else $error("exhausting allocation did not halt");

    // Result register is never overwritten while a result waits
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
        else $error("result loaded over a pending result");

    // Out-of-frames results carry a zero address
    a_exh_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && outcome_reg == OUT_EXHAUSTED) |=> (out_pa_reg == '0))
        else $error("out-of-frames result with nonzero address");

endmodule

@@ src/direct_mapped_tlb_two_level_walk_top.sv @@
// Top level of the direct-mapped TLB with two-level page walk.
// Instantiates dmtlb_ctrl and dmtlb_dp; depends on dmtlb_pkg.
//
// Translates one 32-bit virtual address per request. After reset the block runs a clearing
// pass over the leaf valid rows (the TLB lines and directory bits are cleared alongside) and
// holds s_axis_tready low meanwhile; cfg_we is honored at all times. A request then passes
// through accept with the store read, lookup, one step per frame allocated on a miss (0 to 3:
// root, directory, leaf), a line fill unless the supply ran out, and the response, which waits
// while a result is pending; the single-ported stores are read once at accept and then
// updated one per controller step. A new request is taken while the previous result still
// waits in the output register. The frame limit register is written through cfg_we/cfg_wdata
// and must only be changed while no request is in flight. Once the frame counter reaches the
// limit the block answers every request with outcome 3 and address zero until reset.
module direct_mapped_tlb_two_level_walk_top
    import dmtlb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Config: frame_limit
    input  logic              cfg_we,
    input  logic [NF_W-1:0]   cfg_wdata,
    // Request side
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [VA_W-1:0]   s_axis_tdata,  // [31:0] virtual_address
    // Result side
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [127:0]      m_axis_tdata,  // [31:0] physical_address, [63:32] hit_count,
                                             // [95:64] cold_miss_count,
                                             // [127:96] conflict_miss_count
    output logic [1:0]        m_axis_tuser   // [1:0] outcome
);

    dp_cmd_t          cmd;
    dp_sts_t          sts;
    logic [VA_W-1:0]  pa;
    outcome_t         outcome;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] cold;
    logic [CNT_W-1:0] conflict;

    dmtlb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dmtlb_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_va        (s_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .sts          (sts),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_pa       (pa),
        .out_outcome  (outcome),
        .out_hits     (hits),
        .out_cold     (cold),
        .out_conflict (conflict)
    );

    assign m_axis_tdata = {conflict, cold, hits, pa};
    assign m_axis_tuser = outcome;

endmodule

@@ bench/direct_mapped_tlb_two_level_walk_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for direct_mapped_tlb_two_level_walk_top: directed table, then random
// address streams checked against a behavioral translation model. Depends on dmtlb_pkg.
module direct_mapped_tlb_two_level_walk_top_test;
    import dmtlb_pkg::*;

    localparam int STALL_LIMIT = 200000;

    // One translation as the block reports it
    typedef struct packed {
        logic [VA_W-1:0]  phys;
        outcome_t         outcome;
        logic [CNT_W-1:0] hit_cnt;
        logic [CNT_W-1:0] cold_cnt;
        logic [CNT_W-1:0] conflict_cnt;
    } translation_t;

    // Directed stimulus row; phys/outcome are only used when typed is set
    typedef struct {
        logic [VA_W-1:0] va;
        bit              typed;
        logic [VA_W-1:0] phys;
        outcome_t        outcome;
    } directed_row_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [NF_W-1:0]   cfg_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [VA_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [127:0]      m_axis_tdata;   // [31:0] physical_address, [63:32] hit_count,
                                       // [95:64] cold_miss_count,
                                       // [127:96] conflict_miss_count
    logic [1:0]        m_axis_tuser;   // [1:0] outcome

    // Translation model state
    line_t                tlb_lines [1 << TAB_BITS];
    bit                   root_present;
    bit                   dir_valid [1 << DIR_BITS];
    logic [FRAME_W-1:0]   leaf_frames [int unsigned];
    logic [NF_W-1:0]      frame_counter;
    logic [NF_W-1:0]      limit_setting;
    bit                   model_halted;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     cold_total;
    logic [CNT_W-1:0]     conflict_total;

    translation_t         pending_translations [$];
    int unsigned          mismatch_count = 0;
    int unsigned          stalled_cycles = 0;
    int unsigned          requests_sent = 0;
    bit                   sender_steady = 1'b0;

    // Address pools for the random stream
    logic [DIR_BITS-1:0]  dir_pool [8];
    logic [TAB_BITS-1:0]  tab_pool [12];
    logic [FRAME_W-1:0]   recent_pages [$];

    directed_row_t        directed_rows [20];

    direct_mapped_tlb_two_level_walk_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Model state after reset
    initial
    begin
        foreach (tlb_lines[i])
        begin
            tlb_lines[i] = '0;
        end
        foreach (dir_valid[i])
        begin
            dir_valid[i] = 1'b0;
        end
        root_present   = 1'b0;
        frame_counter  = '0;
        limit_setting  = LIMIT_RESET;
        model_halted   = 1'b0;
        hit_total      = '0;
        cold_total     = '0;
        conflict_total = '0;
    end

    // Bump allocator; returns 0 and halts when the counter lands on the limit
    function automatic bit grab_frame(output logic [FRAME_W-1:0] frame);
        frame = frame_counter[FRAME_W-1:0];
        frame_counter = frame_counter + 1'b1;
        if (frame_counter == limit_setting)
        begin
            model_halted = 1'b1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Translate one address and advance the model
    function automatic translation_t translate_address(input logic [VA_W-1:0] va);
        logic [OFF_BITS-1:0] offset;
        logic [TAB_BITS-1:0] tab;
        logic [DIR_BITS-1:0] dir;
        int unsigned         leaf_idx;
        logic [FRAME_W-1:0]  frame;
        outcome_t            kind;
        bit                  ok;
        translation_t        res;
        offset   = va[OFF_BITS-1:0];
        tab      = va[OFF_BITS +: TAB_BITS];
        dir      = va[OFF_BITS + TAB_BITS +: DIR_BITS];
        leaf_idx = 32'({dir, tab});
        res.phys    = '0;
        res.outcome = OUT_EXHAUSTED;
        if (!model_halted)
        begin
            if (tlb_lines[tab].valid && tlb_lines[tab].tag == dir)
            begin
                hit_total++;
                res.phys    = {tlb_lines[tab].frame, offset};
                res.outcome = OUT_HIT;
            end
            else
            begin
                kind = tlb_lines[tab].valid ? OUT_CONFLICT : OUT_COLD;
                ok   = 1'b1;
                // Walk: root, directory entry, leaf, allocating on demand
                if (!root_present)
                begin
                    ok = grab_frame(frame);
                    if (ok)
                        root_present = 1'b1;
                end
                if (ok && !dir_valid[dir])
                begin
                    ok = grab_frame(frame);
                    if (ok)
                        dir_valid[dir] = 1'b1;
                end
                if (ok && !leaf_frames.exists(leaf_idx))
                begin
                    ok = grab_frame(frame);
                    if (ok)
                        leaf_frames[leaf_idx] = frame;
                end
                if (ok)
                begin
                    frame = leaf_frames[leaf_idx];
                    tlb_lines[tab].valid = 1'b1;
                    tlb_lines[tab].tag   = dir;
                    tlb_lines[tab].frame = frame;
                    if (kind == OUT_COLD)
                        cold_total++;
                    else
                        conflict_total++;
                    res.phys    = {frame, offset};
                    res.outcome = kind;
                end
            end
        end
        res.hit_cnt      = hit_total;
        res.cold_cnt     = cold_total;
        res.conflict_cnt = conflict_total;
        return res;
    endfunction

    // Mix of recent pages (hits), pooled pages (conflicts) and fresh pages (walks)
    function automatic logic [VA_W-1:0] pick_address();
        int unsigned        pick;
        logic [FRAME_W-1:0] page;
        pick = $urandom_range(0, 99);
        if (pick < 35 && recent_pages.size() != 0)
            page = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
        else if (pick < 70)
            page = {dir_pool[$urandom_range(0, 7)], tab_pool[$urandom_range(0, 11)]};
        else
            page = FRAME_W'($urandom);
        recent_pages.push_back(page);
        if (recent_pages.size() > 8)
            void'(recent_pages.pop_front());
        return {page, OFF_BITS'($urandom)};
    endfunction

    // Present one request, wait for the handshake, record what should come back
    task automatic send_request(input logic [VA_W-1:0] va, input bit typed,
                                input logic [VA_W-1:0] typed_phys, input outcome_t typed_outcome);
        int unsigned  gap;
        translation_t want;
        if (requests_sent % 64 == 0)
            sender_steady = ($urandom_range(0, 3) == 0);
        gap = sender_steady ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= va;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        requests_sent++;
        want = translate_address(va);
        if (typed)
        begin
            want.phys    = typed_phys;
            want.outcome = typed_outcome;
        end
        pending_translations.push_back(want);
    endtask

    task automatic run_random_requests(input int unsigned count);
        foreach (dir_pool[i])
        begin
            dir_pool[i] = DIR_BITS'($urandom);
        end
        foreach (tab_pool[i])
        begin
            tab_pool[i] = TAB_BITS'($urandom);
        end
        repeat (count) send_request(pick_address(), 1'b0, '0, OUT_HIT);
    endtask

    // Limit is only changed with no request in flight
    task automatic write_frame_limit(input logic [NF_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_translations.size() != 0) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we        <= 1'b0;
        limit_setting = value;
    endtask

    task automatic compare_field(input string field, input logic [31:0] expected_v,
                                 input logic [31:0] actual_v);
        if (actual_v !== expected_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", field, expected_v, actual_v);
            mismatch_count++;
        end
    endtask

    // Result side: random back-pressure, in-order compare
    initial
    begin
        translation_t want;
        int unsigned  stall;
        int unsigned  results_seen;
        bit           reader_steady;
        results_seen  = 0;
        reader_steady = 1'b0;
        forever
        begin
            if (results_seen % 48 == 0)
                reader_steady = ($urandom_range(0, 3) == 0);
            stall = reader_steady ? 0 : $urandom_range(0, 8);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (m_axis_tvalid !== 1'b1);
            results_seen++;
            if (pending_translations.size() == 0)
            begin
                $error("result with no request waiting: address %0h", m_axis_tdata[31:0]);
                mismatch_count++;
            end
            else
            begin
                want = pending_translations.pop_front();
                compare_field("physical_address", want.phys, m_axis_tdata[31:0]);
                compare_field("outcome", 32'(want.outcome), 32'(m_axis_tuser));
                compare_field("hit_count", want.hit_cnt, m_axis_tdata[63:32]);
                compare_field("cold_miss_count", want.cold_cnt, m_axis_tdata[95:64]);
                compare_field("conflict_miss_count", want.conflict_cnt, m_axis_tdata[127:96]);
            end
        end
    end

    // Watchdog: cycles without any handshake on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stalled_cycles <= 0;
        else
        begin
            stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles == STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Main sequence
    initial
    begin
        // Frame numbers assume a zero limit (never matched) from reset
        directed_rows = '{
            '{32'h0000_0000, 1'b1, 32'h0000_2000, OUT_COLD},      // root, dir, leaf
            '{32'h0000_0FFF, 1'b1, 32'h0000_2FFF, OUT_HIT},
            '{32'hFFFF_FFFF, 1'b1, 32'h0000_4FFF, OUT_COLD},      // top corner
            '{32'hFFFF_F000, 1'b1, 32'h0000_4000, OUT_HIT},
            '{32'hFFC0_0000, 1'b1, 32'h0000_5000, OUT_CONFLICT},  // new leaf only
            '{32'h0000_0123, 1'b1, 32'h0000_2123, OUT_CONFLICT},  // leaf already mapped
            '{32'h003F_F000, 1'b1, 32'h0000_6000, OUT_CONFLICT},
            '{32'hFFC0_0ABC, 1'b1, 32'h0000_5ABC, OUT_CONFLICT},
            '{32'hFFC0_0001, 1'b1, 32'h0000_5001, OUT_HIT},
            '{32'h8000_0000, 1'b1, 32'h0000_8000, OUT_CONFLICT},  // dir and leaf
            '{32'h0040_1000, 1'b1, 32'h0000_A000, OUT_COLD},
            '{32'hAAAA_AAAA, 1'b0, 32'h0, OUT_HIT},
            '{32'h5555_5555, 1'b0, 32'h0, OUT_HIT},
            '{32'h1234_5678, 1'b0, 32'h0, OUT_HIT},
            '{32'hAAAA_A555, 1'b0, 32'h0, OUT_HIT},
            '{32'h5555_5AAA, 1'b0, 32'h0, OUT_HIT},
            '{32'h7FFF_FFFF, 1'b0, 32'h0, OUT_HIT},
            '{32'h8000_0FFF, 1'b0, 32'h0, OUT_HIT},
            '{32'h0040_1FFF, 1'b0, 32'h0, OUT_HIT},
            '{32'h0000_1000, 1'b0, 32'h0, OUT_HIT}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Zero limit: never matched
        write_frame_limit('0);
        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].va, directed_rows[i].typed,
                         directed_rows[i].phys, directed_rows[i].outcome);
        end

        // Limits that are never reached in this run
        write_frame_limit({NF_W{1'b1}});
        run_random_requests(320);
        write_frame_limit(NF_W'(1));            // below the current counter
        run_random_requests(320);
        write_frame_limit(NF_W'(1 << 20));
        run_random_requests(320);
        write_frame_limit(frame_counter + NF_W'($urandom_range(5000, 100000)));
        run_random_requests(320);

        // Exhaust the frame supply a few allocations ahead, then stay halted
        write_frame_limit(frame_counter + NF_W'($urandom_range(2, 6)));
        while (!model_halted)
        begin
            send_request(pick_address(), 1'b0, '0, OUT_HIT);
        end
        run_random_requests(20);
        send_request(32'h0000_0000, 1'b1, 32'h0, OUT_EXHAUSTED);
        send_request(32'hFFFF_FFFF, 1'b1, 32'h0, OUT_EXHAUSTED);

        // Drain
        s_axis_tvalid <= 1'b0;
        while (pending_translations.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
